// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Include guarded; holds macros only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert an implication on every clock, quiet during reset
`define A_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// assert an implication whose consequent is checked in the next cycle
`define A_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// File: hw/rtl/rtfh_pkg.sv
// Package for the ray/triangle first-hit block: payload types, register indexes.
// No dependencies.
package rtfh_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned WideW   = 128;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic               last_triangle;
    } t_tri_in;

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
    } t_hit_out;

    // front-to-back queue entry: classified triangle
    typedef struct packed {
        logic              cand;   // nonzero den and tn, passes the sign tests
        logic [WideW-1:0]  num;    // tn shifted by frac bits
        logic [WideW-1:0]  dvs;    // 2*den, positive
        logic              last;
    } t_job;
endpackage

// File: hw/rtl/rtfh_mul.sv
// Sequencer-driven signed multiplier, 34x34 per partial product, 4 partials per pass.
// Depends on rtfh_pkg.
module rtfh_mul
    import rtfh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic signed [WideW-1:0] i_a,
    input  logic signed [WideW-1:0] i_b,
    output logic              o_done,
    output logic signed [WideW-1:0] o_p
);
    // operands are at most 66 bits signed; split into signed hi / unsigned lo halves
    logic [2:0]  r_step;
    logic        r_busy;
    logic signed [65:0] r_a;
    logic signed [65:0] r_b;
    logic signed [WideW-1:0] r_acc;
    logic signed [WideW-1:0] r_part;
    logic signed [33:0] w_x;
    logic signed [33:0] w_y;
    logic signed [67:0] w_pp;
    logic [6:0] w_sh;

    always_comb begin
        w_x = '0;
        w_y = '0;
        w_sh = '0;
        case (r_step[1:0])
            2'd0: begin
                w_x = {2'b00, r_a[31:0]}; w_y = {2'b00, r_b[31:0]}; w_sh = 7'd0;
            end
            2'd1: begin
                w_x = {2'b00, r_a[31:0]}; w_y = r_b[65:32]; w_sh = 7'd32;
            end
            2'd2: begin
                w_x = r_a[65:32]; w_y = {2'b00, r_b[31:0]}; w_sh = 7'd32;
            end
            default: begin
                w_x = r_a[65:32]; w_y = r_b[65:32]; w_sh = 7'd64;
            end
        endcase
    end

    // full-width partial product
    assign w_pp = w_x * w_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_a    <= 66'(i_a);
                r_b    <= 66'(i_b);
                r_acc  <= '0;
                r_part <= '0;
            end else if (r_busy) begin
                // register the product, then accumulate it shifted
                r_part <= WideW'(w_pp) <<< w_sh;
                if (r_step != 3'd0) r_acc <= r_acc + r_part;
                r_step <= r_step + 3'd1;
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_p    <= r_acc + r_part;
                end
            end
        end
    end
endmodule

// File: hw/rtl/rtfh_front.sv
// Front part: accepts triangles, computes den/tn/un/vn with a shared multiplier,
// classifies and pushes a job. Depends on rtfh_pkg and rtfh_mul.
module rtfh_front
    import rtfh_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_tri_in           i_tri,
    input  logic signed [31:0] i_org [3],
    input  logic signed [31:0] i_dir [3],
    output logic              o_push,
    output t_job              o_job,
    input  logic              i_full
);
    typedef enum logic [1:0] { S_IDLE, S_MUL, S_WAIT, S_PUSH } t_state;
    t_state r_state;
    logic [4:0] r_op;
    logic signed [WideW-1:0] r_e1 [3];
    logic signed [WideW-1:0] r_e2 [3];
    logic signed [WideW-1:0] r_s  [3];
    logic signed [WideW-1:0] r_t  [3];   // N, P, Q staging
    logic signed [WideW-1:0] r_den, r_tn, r_un, r_vn, r_acc;
    logic r_last;
    logic w_start, w_done;
    logic signed [WideW-1:0] w_a, w_b, w_p;
    logic signed [WideW-1:0] n_den, n_tn, n_un, n_vn, n_wn;
    logic w_cross, w_first, w_dot0;
    logic [1:0] w_tidx;
    localparam logic [4:0] LastOp = 5'd29;

    rtfh_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_a(w_a), .i_b(w_b), .o_done(w_done), .o_p(w_p)
    );

    // operand schedule: ops 0-5 N, 6-8 den, 9-11 N.S, 12-17 P, 18-20 un,
    // 21-26 Q, 27-29 vn
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_op)
            5'd0:  begin w_a = r_e1[1]; w_b = r_e2[2]; end
            5'd1:  begin w_a = r_e1[2]; w_b = r_e2[1]; end
            5'd2:  begin w_a = r_e1[2]; w_b = r_e2[0]; end
            5'd3:  begin w_a = r_e1[0]; w_b = r_e2[2]; end
            5'd4:  begin w_a = r_e1[0]; w_b = r_e2[1]; end
            5'd5:  begin w_a = r_e1[1]; w_b = r_e2[0]; end
            5'd6:  begin w_a = 128'(i_dir[0]); w_b = r_t[0]; end
            5'd7:  begin w_a = 128'(i_dir[1]); w_b = r_t[1]; end
            5'd8:  begin w_a = 128'(i_dir[2]); w_b = r_t[2]; end
            5'd9:  begin w_a = r_s[0]; w_b = r_t[0]; end
            5'd10: begin w_a = r_s[1]; w_b = r_t[1]; end
            5'd11: begin w_a = r_s[2]; w_b = r_t[2]; end
            5'd12: begin w_a = r_e2[1]; w_b = 128'(i_dir[2]); end
            5'd13: begin w_a = r_e2[2]; w_b = 128'(i_dir[1]); end
            5'd14: begin w_a = r_e2[2]; w_b = 128'(i_dir[0]); end
            5'd15: begin w_a = r_e2[0]; w_b = 128'(i_dir[2]); end
            5'd16: begin w_a = r_e2[0]; w_b = 128'(i_dir[1]); end
            5'd17: begin w_a = r_e2[1]; w_b = 128'(i_dir[0]); end
            5'd18: begin w_a = r_s[0]; w_b = r_t[0]; end
            5'd19: begin w_a = r_s[1]; w_b = r_t[1]; end
            5'd20: begin w_a = r_s[2]; w_b = r_t[2]; end
            5'd21: begin w_a = r_s[1]; w_b = 128'(i_dir[2]); end
            5'd22: begin w_a = r_s[2]; w_b = 128'(i_dir[1]); end
            5'd23: begin w_a = r_s[2]; w_b = 128'(i_dir[0]); end
            5'd24: begin w_a = r_s[0]; w_b = 128'(i_dir[2]); end
            5'd25: begin w_a = r_s[0]; w_b = 128'(i_dir[1]); end
            5'd26: begin w_a = r_s[1]; w_b = 128'(i_dir[0]); end
            5'd27: begin w_a = r_e1[0]; w_b = r_t[0]; end
            5'd28: begin w_a = r_e1[1]; w_b = r_t[1]; end
            default: begin w_a = r_e1[2]; w_b = r_t[2]; end
        endcase
    end

    // decode the op: cross-product pair (first or second term, target) or dot product
    always_comb begin
        w_cross = 1'b0;
        w_first = 1'b0;
        w_tidx  = 2'd0;
        w_dot0  = (r_op == 5'd6) || (r_op == 5'd9) || (r_op == 5'd18) || (r_op == 5'd27);
        if (r_op < 5'd6) begin
            w_cross = 1'b1;
            w_first = !r_op[0];
            w_tidx  = r_op[2:1];
        end else if (r_op >= 5'd12 && r_op < 5'd18) begin
            w_cross = 1'b1;
            w_first = !r_op[0];
            w_tidx  = 2'((r_op - 5'd12) >> 1);
        end else if (r_op >= 5'd21 && r_op < 5'd27) begin
            w_cross = 1'b1;
            w_first = r_op[0];
            w_tidx  = 2'((r_op - 5'd21) >> 1);
        end
    end

    assign w_start = (r_state == S_MUL);
    assign o_stall = (r_state != S_IDLE);

    // sign-normalize and classify
    always_comb begin
        n_den = r_den;
        n_tn  = -r_tn;
        n_un  = r_un;
        n_vn  = r_vn;
        if (r_den[WideW-1]) begin
            n_den = -r_den; n_tn = r_tn; n_un = -r_un; n_vn = -r_vn;
        end
        n_wn = n_den - n_un - n_vn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= '0;
            o_push  <= 1'b0;
        end else begin
            o_push <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_e1[0] <= 128'(i_tri.b_x) - 128'(i_tri.a_x);
                        r_e1[1] <= 128'(i_tri.b_y) - 128'(i_tri.a_y);
                        r_e1[2] <= 128'(i_tri.b_z) - 128'(i_tri.a_z);
                        r_e2[0] <= 128'(i_tri.c_x) - 128'(i_tri.a_x);
                        r_e2[1] <= 128'(i_tri.c_y) - 128'(i_tri.a_y);
                        r_e2[2] <= 128'(i_tri.c_z) - 128'(i_tri.a_z);
                        r_s[0]  <= 128'(i_org[0]) - 128'(i_tri.a_x);
                        r_s[1]  <= 128'(i_org[1]) - 128'(i_tri.a_y);
                        r_s[2]  <= 128'(i_org[2]) - 128'(i_tri.a_z);
                        r_last  <= i_tri.last_triangle;
                        r_op    <= '0;
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        // cross pairs: hold the first product, store the difference
                        if (w_cross) begin
                            if (w_first) r_acc <= w_p;
                            else r_t[w_tidx] <= r_acc - w_p;
                        end else begin
                            r_acc <= (w_dot0 ? '0 : r_acc) + w_p;
                            if (r_op == 5'd8)   r_den <= r_acc + w_p;
                            if (r_op == 5'd11)  r_tn  <= r_acc + w_p;
                            if (r_op == 5'd20)  r_un  <= r_acc + w_p;
                            if (r_op == LastOp) r_vn  <= r_acc + w_p;
                        end
                        if (r_op == LastOp) begin
                            r_op    <= '0;
                            r_state <= S_PUSH;
                        end else begin
                            r_op    <= r_op + 5'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                default: begin
                    if (!i_full) begin
                        o_push        <= 1'b1;
                        o_job.cand    <= (n_den != '0) && !n_tn[WideW-1] && (n_tn != '0)
                                         && !n_un[WideW-1] && !n_vn[WideW-1]
                                         && !n_wn[WideW-1];
                        o_job.num     <= n_tn << FRAC_BITS;
                        o_job.dvs     <= n_den << 1;
                        o_job.last    <= r_last;
                        r_state       <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule

// File: hw/rtl/rtfh_queue.sv
// Two-entry queue between front and back parts.
// Depends on rtfh_pkg.
module rtfh_queue
    import rtfh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) begin r_mem[r_wp] <= i_job; r_wp <= ~r_wp; end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// File: hw/rtl/rtfh_back.sv
// Back part: restoring divider for t/2, first-hit record, result register.
// Depends on rtfh_pkg.
module rtfh_back
    import rtfh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_job     i_job,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_stall,
    output t_hit_out o_res
);
    typedef enum logic [1:0] { S_IDLE, S_DIV, S_DONE } t_state;
    t_state r_state;
    logic [6:0] r_cnt;
    logic [WideW-1:0] r_num, r_rem, r_dvs;
    logic [32:0] r_q;
    logic r_sat, r_last, r_found;
    logic [31:0] r_fdist;
    logic [WideW-1:0] n_rem;
    logic n_ge;
    logic w_hit;

    always_comb begin
        n_rem = {r_rem[WideW-2:0], r_num[WideW-1]};
        n_ge  = (n_rem >= r_dvs);
    end
    assign o_pop = (r_state == S_IDLE) && !i_empty && !(o_valid && i_stall);

    // quotient fits and is not the all-ones no-hit code
    assign w_hit = !r_sat && (r_q[31:0] != '1) && !r_q[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_found <= 1'b0;
            r_fdist <= '1;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_num  <= i_job.num;
                        r_dvs  <= i_job.dvs;
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_sat  <= !(i_job.cand && !r_found);
                        r_cnt  <= '0;
                        r_last <= i_job.last;
                        r_state <= (i_job.cand && !r_found) ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    r_rem <= n_ge ? n_rem - r_dvs : n_rem;
                    r_num <= r_num << 1;
                    r_q   <= {r_q[31:0], n_ge};
                    if (r_q[32] || (r_cnt < 7'd95 && n_ge)) r_sat <= 1'b1;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) r_state <= S_DONE;
                end
                default: begin
                    // close the object, or record the first hit
                    if (r_last) begin
                        o_valid        <= 1'b1;
                        o_res.hit      <= w_hit || r_found;
                        o_res.distance <= r_found ? r_fdist : (w_hit ? r_q[31:0] : '1);
                        r_found        <= 1'b0;
                        r_fdist        <= '1;
                    end else if (w_hit) begin
                        r_found <= 1'b1;
                        r_fdist <= r_q[31:0];
                    end
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// File: hw/rtl/ray_triangle_first_hit.sv
// Top level of the ray/triangle first-hit block.
// Depends on rtfh_pkg, rtfh_front, rtfh_queue, rtfh_back.
//
// Usage: write ray origin and direction through the register port while idle.
// Stream triangles on the input channel (i_valid/o_stall); the triangle with
// last_triangle set closes an object and yields one transaction on the output
// channel (o_valid/i_stall) carrying hit and distance (t/2, unsigned Q16.16,
// all ones when nothing was hit).
// Throughput is set by the front: it runs 30 products on the shared
// multiplier between an accept state and a push state, and takes no new
// triangle before it has pushed the job. The back divider runs only for
// candidate triangles and is faster than the front, so it keeps up, and
// the two overlap via a two-entry queue. The last triangle's result passes
// the front, the queue, the divider if it is divided, and the result register.
// Reset clears the registers, the queue and the first-hit record.
// While the receiver stalls, the result holds, the back stops popping, the
// queue fills, the front holds its job and then the input stalls.
module ray_triangle_first_hit
    import rtfh_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_tri_in     i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_hit_out    o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    logic signed [31:0] r_org [3];
    logic signed [31:0] r_dir [3];
    logic w_push, w_full, w_pop, w_empty;
    t_job w_job_in, w_job_out;

    // hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org <= '{default: '0};
            r_dir <= '{default: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_org[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                REG_DIR_X:    r_dir[0] <= i_cfg_data;
                REG_DIR_Y:    r_dir[1] <= i_cfg_data;
                REG_DIR_Z:    r_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rtfh_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_tri(i_data), .i_org(r_org), .i_dir(r_dir),
        .o_push(w_push), .o_job(w_job_in), .i_full(w_full)
    );

    rtfh_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_job(w_job_in),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_empty), .o_job(w_job_out)
    );

    rtfh_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_job(w_job_out),
        .o_pop(w_pop), .o_valid(o_valid), .i_stall(i_stall), .o_res(o_data)
    );
endmodule

// File: hw/rtl/rtfh_checker.sv
// Port-level checker for the first-hit block, bound to the top level.
// Depends on rtfh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rtfh_port_checks
    import rtfh_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_valid,
    input logic     i_stall,
    input t_hit_out o_data
);
    // a missed hit always carries the all-ones distance
    `A_IMPLY(a_nohit_dist, i_clk, i_rst_n, o_valid && !o_data.hit, o_data.distance == '1, "no-hit distance not all ones")
    // a hit never carries the all-ones distance
    `A_IMPLY(a_hit_dist, i_clk, i_rst_n, o_valid && o_data.hit, o_data.distance != '1, "hit with saturated distance")
    // a stalled result stays
    `A_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "result dropped under stall")
endmodule

bind ray_triangle_first_hit rtfh_port_checks u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
